### sv/tgar_pkg.sv
package tgar_pkg;

  // Widths of the fields of one transaction.
  localparam int NODE_W  = 12;
  localparam int DELAY_W = 31;
  localparam int TIME_W  = 32;

  // Item kinds.
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BWD  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  // Saturation limits of a time in picoseconds.
  localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;

  // One stored time: the valid bit stands for "not yet defined".
  typedef struct packed {
    logic                     valid;
    logic signed [TIME_W-1:0] value;
  } time_t;

  localparam time_t TIME_NONE = '{valid: 1'b0, value: '0};

  // Item controls handed to the relaxation unit.
  typedef struct packed {
    logic [1:0]         cmd;
    logic               other_ok;
    logic [DELAY_W-1:0] delay;
    logic               is_pi;
    logic               is_po;
    logic               first;
  } relax_ctl_t;

  // Updated times of the addressed node.
  typedef struct packed {
    time_t arr;
    time_t req;
  } relax_res_t;

endpackage

### sv/tgar_tmem.sv
module tgar_tmem
  import tgar_pkg::*;
#(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output time_t         rd_data_a,
  output time_t         rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  time_t         wr_data
);

  time_t mem [DEPTH];

  // Two registered read ports and one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### sv/tgar_relax.sv
module tgar_relax
  import tgar_pkg::*;
(
  input  relax_ctl_t         ctl,
  input  logic [DELAY_W-1:0] clock_period,
  input  time_t              arr_cur,
  input  time_t              arr_oth,
  input  time_t              req_cur,
  input  time_t              req_oth,
  output relax_res_t         res
);

  time_t             src;
  time_t             snk;
  logic [TIME_W:0]   sum_ext;
  logic [TIME_W:0]   diff_ext;
  time_t             sum;
  time_t             diff;

  // An operand beyond the node range reads as undefined.
  assign src = ctl.other_ok ? arr_oth : TIME_NONE;
  assign snk = ctl.other_ok ? req_oth : TIME_NONE;

  // Source arrival plus delay, saturated at the largest time.
  assign sum_ext = {src.value[TIME_W-1], src.value} + {2'b00, ctl.delay};
  always_comb begin
    sum.valid = src.valid;
    if (!src.valid) begin
      sum.value = '0;
    end else if (sum_ext[TIME_W:TIME_W-1] == 2'b01) begin
      sum.value = TIME_MAX;
    end else begin
      sum.value = sum_ext[TIME_W-1:0];
    end
  end

  // Sink required minus delay, saturated at the smallest time.
  assign diff_ext = {snk.value[TIME_W-1], snk.value} - {2'b00, ctl.delay};
  always_comb begin
    diff.valid = snk.valid;
    if (!snk.valid) begin
      diff.value = '0;
    end else if (diff_ext[TIME_W:TIME_W-1] == 2'b10) begin
      diff.value = TIME_MIN;
    end else begin
      diff.value = diff_ext[TIME_W-1:0];
    end
  end

  // New times of the node for each item kind.
  always_comb begin
    res.arr = arr_cur;
    res.req = req_cur;
    case (ctl.cmd)
      CMD_INIT: begin
        res.arr.valid = ctl.is_pi;
        res.arr.value = '0;
        res.req.valid = ctl.is_po;
        res.req.value = ctl.is_po ? {1'b0, clock_period} : '0;
      end
      CMD_FWD: begin
        if (ctl.first || !arr_cur.valid) begin
          res.arr = sum;
        end else if (!sum.valid) begin
          res.arr = TIME_NONE;
        end else if (sum.value > arr_cur.value) begin
          res.arr = sum;
        end
      end
      CMD_BWD: begin
        if (!req_cur.valid) begin
          res.req = diff;
        end else if (!diff.valid) begin
          res.req = TIME_NONE;
        end else if (diff.value < req_cur.value) begin
          res.req = diff;
        end
      end
      default: begin
        res.arr = arr_cur;
        res.req = req_cur;
      end
    endcase
  end

endmodule

### sv/timing_graph_arrival_required.sv
// Arrival and required time store for a timing graph of NODE_COUNT nodes. Each
// accepted transaction (init node, forward edge, backward edge or read node)
// returns the node's two times as they are after it, one result per
// transaction. A transaction first reads the node and the other node from both
// time memories, then computes the saturated sum or difference with max or min
// and writes the entry back; no new transaction is taken while one is in the
// compute stage. After reset a clearing pass marks every entry undefined; the
// input channel stalls during it, while clock_period writes are taken at any
// time.
module timing_graph_arrival_required
  import tgar_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [DELAY_W-1:0]       cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [NODE_W-1:0]        in_node,
  input  logic [NODE_W-1:0]        in_other_node,
  input  logic [DELAY_W-1:0]       in_delay,
  input  logic                     in_is_primary_input,
  input  logic                     in_is_primary_output,
  input  logic                     in_first_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TIME_W-1:0] out_arrival,
  output logic                     out_arrival_valid,
  output logic signed [TIME_W-1:0] out_required,
  output logic                     out_required_valid
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int XW = AW + NODE_W;

  logic [DELAY_W-1:0] clock_period_r;
  logic               clearing_r;
  logic [AW-1:0]      clr_idx_r;
  logic               s1_valid_r;
  logic [AW-1:0]      s1_idx_r;
  logic               s1_node_ok_r;
  relax_ctl_t         s1_ctl_r;
  logic               out_valid_r;
  relax_res_t         out_res_r;

  logic               in_fire;
  logic               s1_fire;
  logic [XW-1:0]      node_ext;
  logic [XW-1:0]      other_ext;
  logic [AW-1:0]      node_idx;
  logic [AW-1:0]      other_idx;
  logic               node_ok;
  logic               other_ok;
  time_t              arr_cur;
  time_t              arr_oth;
  time_t              req_cur;
  time_t              req_oth;
  relax_res_t         res;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  time_t              arr_wr;
  time_t              req_wr;

  // Handshakes: one transaction in flight, the output register parts the sides.
  assign in_stall = clearing_r | s1_valid_r;
  assign in_fire  = in_valid & ~in_stall;
  assign s1_fire  = s1_valid_r & (~out_valid_r | ~out_stall);

  // Node numbers mapped onto the memory index and checked against the range.
  assign node_ext  = {{AW{1'b0}}, in_node};
  assign other_ext = {{AW{1'b0}}, in_other_node};
  assign node_idx  = node_ext[AW-1:0];
  assign other_idx = other_ext[AW-1:0];
  assign node_ok   = {{(32 - NODE_W){1'b0}}, in_node} < 32'(NODE_COUNT);
  assign other_ok  = {{(32 - NODE_W){1'b0}}, in_other_node} < 32'(NODE_COUNT);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_period_r <= '0;
    end else if (cfg_wr_en) begin
      clock_period_r <= cfg_wr_data;
    end
  end

  // Clearing pass over every entry after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(NODE_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Compute stage: holds the transaction while the memories return its operands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r          <= node_idx;
      s1_node_ok_r      <= node_ok;
      s1_ctl_r.cmd      <= in_cmd;
      s1_ctl_r.other_ok <= other_ok;
      s1_ctl_r.delay    <= in_delay;
      s1_ctl_r.is_pi    <= in_is_primary_input;
      s1_ctl_r.is_po    <= in_is_primary_output;
      s1_ctl_r.first    <= in_first_edge;
    end
  end

  // Arrival and required time memories.
  tgar_tmem #(
    .DEPTH (NODE_COUNT)
  ) u_arr_mem (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr_a (node_idx),
    .rd_addr_b (other_idx),
    .rd_data_a (arr_cur),
    .rd_data_b (arr_oth),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (arr_wr)
  );

  tgar_tmem #(
    .DEPTH (NODE_COUNT)
  ) u_req_mem (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr_a (node_idx),
    .rd_addr_b (other_idx),
    .rd_data_a (req_cur),
    .rd_data_b (req_oth),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (req_wr)
  );

  // Edge relaxation and node init.
  tgar_relax u_relax (
    .ctl          (s1_ctl_r),
    .clock_period (clock_period_r),
    .arr_cur      (arr_cur),
    .arr_oth      (arr_oth),
    .req_cur      (req_cur),
    .req_oth      (req_oth),
    .res          (res)
  );

  // Write back: the clearing pass, else the finished transaction.
  assign wr_en   = clearing_r |
                   (s1_fire & s1_node_ok_r & (s1_ctl_r.cmd != CMD_READ));
  assign wr_addr = clearing_r ? clr_idx_r : s1_idx_r;
  assign arr_wr  = clearing_r ? TIME_NONE : res.arr;
  assign req_wr  = clearing_r ? TIME_NONE : res.req;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_node_ok_r) begin
        out_res_r <= res;
      end else begin
        out_res_r.arr <= TIME_NONE;
        out_res_r.req <= TIME_NONE;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_arrival        = out_res_r.arr.valid ? out_res_r.arr.value : '0;
  assign out_arrival_valid  = out_res_r.arr.valid;
  assign out_required       = out_res_r.req.valid ? out_res_r.req.value : '0;
  assign out_required_valid = out_res_r.req.valid;

  // The compute stage never overlaps the clearing pass.
  a_no_work_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) s1_valid_r |-> !clearing_r
  ) else $error("transaction in flight during clearing pass");

  // An accepted transaction occupies the compute stage in the next cycle.
  a_accept_loads_stage: assert property (
    @(posedge clk) disable iff (!rst_n) in_fire |=> s1_valid_r
  ) else $error("accepted transaction lost before compute");

  // A finished transaction always shows on the output in the next cycle.
  a_result_follows: assert property (
    @(posedge clk) disable iff (!rst_n) s1_fire |=> out_valid_r
  ) else $error("finished transaction did not reach the output");

  // A blocked compute stage keeps its transaction unchanged.
  a_stage_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_idx_r) && $stable(s1_ctl_r))
  ) else $error("blocked compute stage changed");

  // Outside the clearing pass, memories are written only by a finished transaction.
  a_write_source: assert property (
    @(posedge clk) disable iff (!rst_n) (wr_en && !clearing_r) |-> s1_fire
  ) else $error("stray memory write");

endmodule
